>>> rtl/dboc_pkg.sv
// shared types and constants for the dual beam occupancy counter
`timescale 1ns / 1ps
`default_nettype none

package dboc_pkg;

  localparam int RANGE_W = 12;
  localparam int SUM_W   = 16;
  localparam int WIN_W   = 4;
  localparam int OCC_W   = 11;
  localparam int LIMIT_W = 10;
  localparam int CFG_W   = 12;
  localparam int IDX_W   = 1;

  localparam int CAL_SAMPLES = 10;
  localparam int CAL_HALF    = CAL_SAMPLES / 2;
  localparam int CAL_SHIFT   = 21;
  localparam int RECIP_W     = 22;
  localparam int CAL_RECIP   = (2 ** CAL_SHIFT + CAL_SAMPLES - 1) / CAL_SAMPLES;
  localparam int NUM_W       = SUM_W + 1;
  localparam int PROD_W      = NUM_W + RECIP_W;

  localparam logic [IDX_W-1:0] REG_OCC_LIMIT   = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_RANGE_LIMIT = IDX_W'(1);

  localparam logic [LIMIT_W-1:0] OCC_LIMIT_RST   = LIMIT_W'(10);
  localparam logic [RANGE_W-1:0] RANGE_LIMIT_RST = RANGE_W'(2000);

  localparam logic signed [OCC_W-1:0] OCC_MAX = 11'sd1023;
  localparam logic signed [OCC_W-1:0] OCC_MIN = -OCC_MAX - 11'sd1;

  typedef struct packed {
    logic [RANGE_W-1:0] range_a_mm;
    logic               range_a_ok;
    logic [RANGE_W-1:0] range_b_mm;
    logic               range_b_ok;
  } reading_t;

  typedef struct packed {
    logic active;
    logic restart;
  } cal_status_t;

  typedef struct packed {
    logic signed [OCC_W-1:0] occupancy;
    logic                    entered_pulse;
    logic                    left_pulse;
    logic                    full_flag;
  } count_result_t;

  typedef struct packed {
    logic signed [OCC_W-1:0] occupancy;
    logic                    entered_pulse;
    logic                    left_pulse;
    logic                    full_flag;
    logic                    calibrating_flag;
    logic                    calibration_restart;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/dual_beam_occupancy_counter_unit.sv
// top level of the dual beam occupancy counter
`timescale 1ns / 1ps
`default_nettype none

// Takes one word of two range readings per cycle while the output is free or being read,
// and returns one result word for each. A word is registered on acceptance, processed in one
// pass through the calibration and counting logic, and held in the output register until read;
// a new word is accepted while the previous one moves on. After reset the first good words
// average into per-sensor baselines; any invalid or out-of-range reading restarts that window.
// The user writes configuration only while idle; the block itself does not enforce this.
module dual_beam_occupancy_counter_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [dboc_pkg::IDX_W-1:0]          cfg_index,
  input  wire logic [dboc_pkg::CFG_W-1:0]          cfg_data,
  input  wire logic                                item_valid,
  output logic                                     item_ready,
  input  wire logic [dboc_pkg::RANGE_W-1:0]        range_a_mm,
  input  wire logic                                range_a_ok,
  input  wire logic [dboc_pkg::RANGE_W-1:0]        range_b_mm,
  input  wire logic                                range_b_ok,
  output logic                                     result_valid,
  input  wire logic                                result_ready,
  output logic signed [dboc_pkg::OCC_W-1:0]        occupancy,
  output logic                                     entered_pulse,
  output logic                                     left_pulse,
  output logic                                     full_flag,
  output logic                                     calibrating_flag,
  output logic                                     calibration_restart
);

  logic [dboc_pkg::LIMIT_W-1:0] occupancy_limit;
  logic [dboc_pkg::RANGE_W-1:0] range_limit_mm;

  logic                         in_full;
  dboc_pkg::reading_t           in_word;
  logic                         out_full;
  dboc_pkg::result_t            out_word;

  logic                         advance;
  dboc_pkg::cal_status_t        cal_status;
  dboc_pkg::count_result_t      cnt_res;
  logic [dboc_pkg::RANGE_W-1:0] baseline_a;
  logic [dboc_pkg::RANGE_W-1:0] baseline_b;
  dboc_pkg::result_t            result_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy_limit <= dboc_pkg::OCC_LIMIT_RST;
      range_limit_mm  <= dboc_pkg::RANGE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dboc_pkg::REG_OCC_LIMIT:   occupancy_limit <= cfg_data[dboc_pkg::LIMIT_W-1:0];
        dboc_pkg::REG_RANGE_LIMIT: range_limit_mm  <= cfg_data[dboc_pkg::RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance    = in_full && (!out_full || result_ready);
  assign item_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item_valid && item_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      in_word.range_a_mm <= range_a_mm;
      in_word.range_a_ok <= range_a_ok;
      in_word.range_b_mm <= range_b_mm;
      in_word.range_b_ok <= range_b_ok;
    end
  end

  dboc_cal u_cal (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .rd             (in_word),
    .range_limit_mm (range_limit_mm),
    .status         (cal_status),
    .baseline_a     (baseline_a),
    .baseline_b     (baseline_b)
  );

  dboc_count u_count (
    .clk             (clk),
    .rst             (rst),
    .step            (advance),
    .enable          (!cal_status.active),
    .rd              (in_word),
    .baseline_a      (baseline_a),
    .baseline_b      (baseline_b),
    .occupancy_limit (occupancy_limit),
    .res             (cnt_res)
  );

  assign result_next.occupancy           = cnt_res.occupancy;
  assign result_next.entered_pulse       = cnt_res.entered_pulse;
  assign result_next.left_pulse          = cnt_res.left_pulse;
  assign result_next.full_flag           = cnt_res.full_flag;
  assign result_next.calibrating_flag    = cal_status.active;
  assign result_next.calibration_restart = cal_status.restart;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance) begin
      out_full <= 1'b1;
    end else if (result_ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= result_next;
    end
  end

  assign result_valid        = out_full;
  assign occupancy           = out_word.occupancy;
  assign entered_pulse       = out_word.entered_pulse;
  assign left_pulse          = out_word.left_pulse;
  assign full_flag           = out_word.full_flag;
  assign calibrating_flag    = out_word.calibrating_flag;
  assign calibration_restart = out_word.calibration_restart;

endmodule

`default_nettype wire

>>> rtl/dboc_cal.sv
// baseline calibration: window sums and rounded averages per sensor
`timescale 1ns / 1ps
`default_nettype none

module dboc_cal (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         step,
  input  wire dboc_pkg::reading_t           rd,
  input  wire logic [dboc_pkg::RANGE_W-1:0] range_limit_mm,
  output dboc_pkg::cal_status_t             status,
  output logic [dboc_pkg::RANGE_W-1:0]      baseline_a,
  output logic [dboc_pkg::RANGE_W-1:0]      baseline_b
);

  logic                         in_calibration;
  logic [dboc_pkg::WIN_W-1:0]   window_count;
  logic [dboc_pkg::SUM_W-1:0]   sum_a;
  logic [dboc_pkg::SUM_W-1:0]   sum_b;

  logic                         bad;
  logic                         done;
  logic [dboc_pkg::WIN_W-1:0]   window_count_next;
  logic [dboc_pkg::SUM_W-1:0]   sum_a_next;
  logic [dboc_pkg::SUM_W-1:0]   sum_b_next;
  logic [dboc_pkg::NUM_W-1:0]   num_a;
  logic [dboc_pkg::NUM_W-1:0]   num_b;
  logic [dboc_pkg::PROD_W-1:0]  prod_a;
  logic [dboc_pkg::PROD_W-1:0]  prod_b;
  logic [dboc_pkg::RECIP_W-1:0] recip;

  assign bad = !rd.range_a_ok || !rd.range_b_ok ||
               (rd.range_a_mm > range_limit_mm) || (rd.range_b_mm > range_limit_mm);

  assign sum_a_next = sum_a + dboc_pkg::SUM_W'(rd.range_a_mm);
  assign sum_b_next = sum_b + dboc_pkg::SUM_W'(rd.range_b_mm);
  assign window_count_next = window_count + dboc_pkg::WIN_W'(1);
  assign done = !bad && (window_count_next >= dboc_pkg::WIN_W'(dboc_pkg::CAL_SAMPLES));

  // divide by the window length through a reciprocal multiply
  assign recip = dboc_pkg::RECIP_W'(dboc_pkg::CAL_RECIP);
  assign num_a = dboc_pkg::NUM_W'(sum_a_next) + dboc_pkg::NUM_W'(dboc_pkg::CAL_HALF);
  assign num_b = dboc_pkg::NUM_W'(sum_b_next) + dboc_pkg::NUM_W'(dboc_pkg::CAL_HALF);
  assign prod_a = dboc_pkg::PROD_W'(num_a) * dboc_pkg::PROD_W'(recip);
  assign prod_b = dboc_pkg::PROD_W'(num_b) * dboc_pkg::PROD_W'(recip);

  assign status.active  = in_calibration;
  assign status.restart = in_calibration && bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_calibration <= 1'b1;
      window_count   <= '0;
      sum_a          <= '0;
      sum_b          <= '0;
      baseline_a     <= '0;
      baseline_b     <= '0;
    end else if (step && in_calibration) begin
      if (bad) begin
        window_count <= '0;
        sum_a        <= '0;
        sum_b        <= '0;
      end else if (done) begin
        window_count   <= '0;
        sum_a          <= '0;
        sum_b          <= '0;
        baseline_a     <= prod_a[dboc_pkg::CAL_SHIFT +: dboc_pkg::RANGE_W];
        baseline_b     <= prod_b[dboc_pkg::CAL_SHIFT +: dboc_pkg::RANGE_W];
        in_calibration <= 1'b0;
      end else begin
        window_count <= window_count_next;
        sum_a        <= sum_a_next;
        sum_b        <= sum_b_next;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/dboc_count.sv
// entry and exit detection with saturating occupancy count
`timescale 1ns / 1ps
`default_nettype none

module dboc_count (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         step,
  input  wire logic                         enable,
  input  wire dboc_pkg::reading_t           rd,
  input  wire logic [dboc_pkg::RANGE_W-1:0] baseline_a,
  input  wire logic [dboc_pkg::RANGE_W-1:0] baseline_b,
  input  wire logic [dboc_pkg::LIMIT_W-1:0] occupancy_limit,
  output dboc_pkg::count_result_t           res
);

  localparam int DEV_W = dboc_pkg::RANGE_W + 3;

  logic                                armed_a;
  logic                                armed_b;
  logic                                entry_blocked;
  logic signed [dboc_pkg::OCC_W-1:0]   head_count;

  logic [dboc_pkg::RANGE_W-1:0]        diff_a;
  logic [dboc_pkg::RANGE_W-1:0]        diff_b;
  logic                                dev_a;
  logic                                dev_b;
  logic                                hit_a;
  logic                                hit_b;
  logic                                entered;
  logic                                left;
  logic signed [dboc_pkg::OCC_W-1:0]   limit_s;
  logic signed [dboc_pkg::OCC_W-1:0]   head_mid;
  logic signed [dboc_pkg::OCC_W-1:0]   head_count_next;
  logic                                blocked_mid;
  logic                                entry_blocked_next;
  logic                                armed_a_next;
  logic                                armed_b_next;

  assign diff_a = (rd.range_a_mm > baseline_a) ? (rd.range_a_mm - baseline_a)
                                               : (baseline_a - rd.range_a_mm);
  assign diff_b = (rd.range_b_mm > baseline_b) ? (rd.range_b_mm - baseline_b)
                                               : (baseline_b - rd.range_b_mm);

  // 5 * |d| > baseline, as d * 4 + d
  assign dev_a = rd.range_a_ok &&
                 ((DEV_W'(diff_a) << 2) + DEV_W'(diff_a) > DEV_W'(baseline_a));
  assign dev_b = rd.range_b_ok &&
                 ((DEV_W'(diff_b) << 2) + DEV_W'(diff_b) > DEV_W'(baseline_b));

  assign limit_s = $signed({1'b0, occupancy_limit});

  // sensor a first, sensor b sees what a left
  assign hit_a   = enable && dev_a && !entry_blocked;
  assign entered = hit_a && !armed_a;
  assign head_mid = (entered && (head_count != dboc_pkg::OCC_MAX))
                    ? head_count + dboc_pkg::OCC_W'(1) : head_count;
  assign blocked_mid = entry_blocked || (entered && (head_mid == limit_s));

  assign hit_b = enable && dev_b;
  assign left  = hit_b && !armed_b;
  assign entry_blocked_next = (left && (head_mid == limit_s)) ? 1'b0 : blocked_mid;
  assign head_count_next = (left && (head_mid != dboc_pkg::OCC_MIN))
                           ? head_mid - dboc_pkg::OCC_W'(1) : head_mid;

  assign armed_a_next = enable ? hit_a : armed_a;
  assign armed_b_next = enable ? hit_b : armed_b;

  assign res.occupancy     = head_count_next;
  assign res.entered_pulse = entered;
  assign res.left_pulse    = left;
  assign res.full_flag     = entry_blocked_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      armed_a       <= 1'b0;
      armed_b       <= 1'b0;
      entry_blocked <= 1'b0;
      head_count    <= '0;
    end else if (step) begin
      armed_a       <= armed_a_next;
      armed_b       <= armed_b_next;
      entry_blocked <= entry_blocked_next;
      head_count    <= head_count_next;
    end
  end

endmodule

`default_nettype wire
